// ===== hdl/fpt_pkg.sv =====
`timescale 1ns / 1ps
package fpt_pkg;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_N = 24;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_TINY = 2'd1,
    CMD_FOOT = 2'd2,
    CMD_INV  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_OFS = 2'd1,
    ST_NO_PREV = 2'd2
  } status_t;

  localparam logic [2:0] REG_OFS_X = 3'd0;
  localparam logic [2:0] REG_OFS_Y = 3'd1;
  localparam logic [2:0] REG_OFS_V = 3'd2;
  localparam logic [2:0] REG_YAW   = 3'd3;
  localparam logic [2:0] REG_MIN   = 3'd4;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic [15:0]        pose_angle;
    logic [31:0]        impact_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [15:0]        out_angle;
    logic               is_tiny;
    logic [1:0]         status;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // latch input item, set up CORDIC
    logic iter;     // one CORDIC rotation
    logic mul_a;    // first product pair
    logic mul_b;    // second product pair
    logic sum;      // round the second product pair
    logic diff;     // add to pose and saturate
    logic sq;       // tiny test deltas
    logic fin;      // form result, update last step
  } dp_cmd_t;

  typedef struct packed {
    logic last_iter;
  } dp_sts_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0: v = 32'd536870912;  5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;  5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;   5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;   5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;    5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;    5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;    5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;     5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;     5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;       5'd21: v = 32'd326;
      5'd22: v = 32'd163;       5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction
endpackage

// ===== hdl/fpt_ctrl.sv =====
`timescale 1ns / 1ps
module fpt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  fpt_pkg::dp_sts_t sts,
  output fpt_pkg::dp_cmd_t cmd
);
  import fpt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ROT, S_MULA, S_MULB, S_SUM, S_DIFF, S_SQ, S_FIN
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  // result register frees once taken; a new item may start while it waits
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    cmd.load  = in_valid && in_ready;
    cmd.iter  = (state_r == S_ROT);
    cmd.mul_a = (state_r == S_MULA);
    cmd.mul_b = (state_r == S_MULB);
    cmd.sum   = (state_r == S_SUM);
    cmd.diff  = (state_r == S_DIFF);
    cmd.sq    = (state_r == S_SQ);
    cmd.fin   = (state_r == S_FIN) && !(out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.fin) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid) state_r <= S_ROT;
        S_ROT:  if (sts.last_iter) state_r <= S_MULA;
        S_MULA: state_r <= S_MULB;
        S_MULB: state_r <= S_SUM;
        S_SUM:  state_r <= S_DIFF;
        S_DIFF: state_r <= S_SQ;
        S_SQ:   state_r <= S_FIN;
        S_FIN: begin
          if (cmd.fin) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/fpt_dp.sv =====
`timescale 1ns / 1ps
module fpt_dp #(
  parameter int CORDIC_STAGES = fpt_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fpt_pkg::in_item_t  in_item,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  fpt_pkg::dp_cmd_t   cmd,
  output fpt_pkg::dp_sts_t   sts,
  output fpt_pkg::out_item_t out_item
);
  import fpt_pkg::*;

  localparam int NST = (CORDIC_STAGES < ATAN_N) ? CORDIC_STAGES : ATAN_N;

  // configuration
  logic signed [23:0] ofs_x_r, ofs_y_r;
  logic               ofs_v_r;
  logic [15:0]        yaw_r;
  logic [22:0]        min_r;
  // last step
  logic signed [31:0] last_x_r, last_y_r;
  logic [15:0]        last_hd_r;
  logic [31:0]        last_t_r;
  logic               have_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_x_r <= '0; ofs_y_r <= '0; ofs_v_r <= 1'b0; yaw_r <= '0; min_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OFS_X: ofs_x_r <= cfg_data[23:0];
        REG_OFS_Y: ofs_y_r <= cfg_data[23:0];
        REG_OFS_V: ofs_v_r <= cfg_data[0];
        REG_YAW:   yaw_r   <= cfg_data[15:0];
        REG_MIN:   min_r   <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  // item latch
  logic [1:0]         cmd_r;
  logic signed [31:0] px_r, py_r;
  logic [15:0]        oa_r;
  logic [31:0]        t_r;
  logic               flip_r;
  // CORDIC
  logic signed [31:0] cx_r, cy_r, cz_r;
  logic [4:0]         it_r;

  logic [15:0] ang;
  always_comb begin
    unique case (cmd_t'(in_item.cmd))
      CMD_INV: ang = in_item.pose_angle - yaw_r;
      default: ang = in_item.pose_angle;
    endcase
  end

  logic [31:0] za;
  assign za = {ang, 16'h0} ^ (((ang[15:14] == 2'b01) || (ang[15:14] == 2'b10)) ?
                              32'h8000_0000 : 32'h0);

  logic signed [31:0] dxs, dys, at;
  assign dxs = cy_r >>> it_r;
  assign dys = cx_r >>> it_r;
  assign at  = atan_lut(it_r);
  assign sts.last_iter = (it_r == 5'(NST - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_item.cmd;
      px_r   <= in_item.pose_x;
      py_r   <= in_item.pose_y;
      t_r    <= in_item.impact_time;
      oa_r   <= ang;
      flip_r <= (ang[15:14] == 2'b01) || (ang[15:14] == 2'b10);
      cx_r   <= 32'sd652032874;
      cy_r   <= '0;
      cz_r   <= za;
      it_r   <= '0;
    end else if (cmd.iter) begin
      if (!cz_r[31]) begin
        cx_r <= cx_r - dxs; cy_r <= cy_r + dys; cz_r <= cz_r - at;
      end else begin
        cx_r <= cx_r + dxs; cy_r <= cy_r - dys; cz_r <= cz_r + at;
      end
      it_r <= it_r + 5'd1;
    end
  end

  // products: |c|,|s| < 2^31, offsets 24 bits -> 57-bit products
  logic signed [32:0] c_s, s_s;
  assign c_s = flip_r ? -33'(cx_r) : 33'(cx_r);
  assign s_s = flip_r ? -33'(cy_r) : 33'(cy_r);

  logic signed [56:0] pa_r, pb_r, pc_r, pd_r;
  logic signed [33:0] rx_r, ry_r;
  always_ff @(posedge clk) begin
    if (cmd.mul_a) begin
      pa_r <= 57'(c_s * ofs_x_r);
      pb_r <= 57'(s_s * ofs_y_r);
    end
    if (cmd.mul_b) begin
      pc_r <= 57'(s_s * ofs_x_r);
      pd_r <= 57'(c_s * ofs_y_r);
      rx_r <= 34'((pa_r - pb_r + 57'sd536870912) >>> 30);
    end
    if (cmd.sum) ry_r <= 34'((pc_r + pd_r + 57'sd536870912) >>> 30);
  end

  function automatic logic signed [31:0] sat(input logic signed [34:0] v);
    if (v > 35'sd2147483647) return 32'sh7fffffff;
    if (v < -35'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic signed [31:0] fx_r, fy_r;
  logic signed [32:0] ddx_r, ddy_r;
  logic signed [34:0] sx, sy;
  assign sx = (cmd_r == CMD_INV) ? 35'(px_r) - 35'(rx_r) : 35'(px_r) + 35'(rx_r);
  assign sy = (cmd_r == CMD_INV) ? 35'(py_r) - 35'(ry_r) : 35'(py_r) + 35'(ry_r);

  logic inrng;
  assign inrng = (ddx_r > -33'sd8388608) && (ddx_r < 33'sd8388608) &&
                 (ddy_r > -33'sd8388608) && (ddy_r < 33'sd8388608);
  logic signed [23:0] dx24, dy24;
  assign dx24 = ddx_r[23:0];
  assign dy24 = ddy_r[23:0];

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      fx_r  <= sat(sx);
      fy_r  <= sat(sy);
    end
    if (cmd.sq) begin
      ddx_r <= 33'(fx_r) - 33'(last_x_r);
      ddy_r <= 33'(fy_r) - 33'(last_y_r);
    end
  end

  // squares formed in the final state from the registered deltas
  logic [47:0] qx, qy, mm;
  assign qx = 48'(dx24 * dx24);
  assign qy = 48'(dy24 * dy24);
  assign mm = 48'(min_r * min_r);

  logic tiny;
  assign tiny = inrng && ((49'(qx) + 49'(qy)) < 49'(mm));

  out_item_t res;
  always_comb begin
    res = '0;
    if (cmd_r == CMD_TINY) begin
      if (!have_r) res.status = ST_NO_PREV;
      else         res.is_tiny = tiny;
    end else if (!ofs_v_r) begin
      res.status = ST_NO_OFS;
    end else begin
      res.out_x = fx_r;
      res.out_y = fy_r;
      if (cmd_r == CMD_INV) res.out_angle = oa_r;
      if (cmd_r == CMD_ADD) res.out_angle = oa_r + yaw_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0; last_x_r <= '0; last_y_r <= '0; last_hd_r <= '0; last_t_r <= '0;
    end else if (cmd.fin) begin
      out_item <= res;
      if ((cmd_r == CMD_ADD) && ofs_v_r) begin
        last_x_r  <= fx_r;
        last_y_r  <= fy_r;
        last_hd_r <= res.out_angle;
        last_t_r  <= t_r;
        have_r    <= 1'b1;
      end
    end
  end
endmodule

// ===== hdl/foot_placement_transform_unit.sv =====
`timescale 1ns / 1ps
// Foot placement transform: rotates the configured foot offset by the pose
// heading (iterative CORDIC, one stage per cycle) and adds it to, or for the
// inverse command subtracts it from, the pose position. Each item runs the
// shared CORDIC rotator for CORDIC_STAGES (capped at 24) iterations, then
// six steps of products, rounding, saturation and the tiny-step compare.
// Items are processed one at a time: the next transaction can be accepted
// in the cycle after the result is formed, which is held back only while an
// earlier finished result waits on out_ready. Configuration must be written
// through the cfg_ channel only while idle; the block does not enforce this.
// cfg_ready is always high.
module foot_placement_transform_unit #(
  parameter int CORDIC_STAGES = fpt_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fpt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fpt_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import fpt_pkg::*;

  dp_cmd_t dcmd;
  dp_sts_t dsts;

  assign cfg_ready = 1'b1;

  fpt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts(dsts), .cmd(dcmd)
  );

  fpt_dp #(.CORDIC_STAGES(CORDIC_STAGES)) u_dp (
    .clk, .rst_n, .in_item(in_data), .cfg_valid, .cfg_index, .cfg_data,
    .cmd(dcmd), .sts(dsts), .out_item(out_data)
  );
endmodule

// ===== hdl/fpt_checker.sv =====
`timescale 1ns / 1ps
module fpt_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [82:0] out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out hold");
  a_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("busy accept");
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid)) else $error("early result");
endmodule

bind foot_placement_transform_unit fpt_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
